[rtl/trmd_pkg.sv]
`timescale 1ns / 1ps

package trmd_pkg;

  // Key words with an instance of their own; paired layout writes the first two.
  localparam int KEY_INSTANCES  = 2;
  localparam bit CHECK_AT_RESET = 1'b1;

  localparam logic [7:0] NO_MESSAGE_ID = 8'hff;
  localparam int         STATUS_RESET_BIT = 7;
  localparam int         APB_ADDR_W = 5;

  localparam logic [2:0] KIND_IGNORED  = 3'd0;
  localparam logic [2:0] KIND_COMMAND  = 3'd1;
  localparam logic [2:0] KIND_TOUCH    = 3'd2;
  localparam logic [2:0] KIND_KEYS     = 3'd3;
  localparam logic [2:0] KIND_SELFTEST = 3'd4;

  localparam logic [1:0] PHASE_NORMAL    = 2'd0;
  localparam logic [1:0] PHASE_PENDING   = 2'd1;
  localparam logic [1:0] PHASE_SUCCEEDED = 2'd2;
  localparam logic [1:0] PHASE_FAILED    = 2'd3;

  localparam logic [1:0] LAYOUT_PAIRED       = 2'd1;
  localparam logic [1:0] LAYOUT_PER_INSTANCE = 2'd2;

  typedef enum logic [2:0] {
    REG_COMMAND_ID    = 3'd0,
    REG_LEGACY_RANGE  = 3'd1,
    REG_NEW_RANGE     = 3'd2,
    REG_KEY_RANGE     = 3'd3,
    REG_SELFTEST_ID   = 3'd4,
    REG_SHIFT_MODE    = 3'd5,
    REG_KEY_LAYOUT    = 3'd6,
    REG_EXP_CHECKSUM  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  command_id;
    logic [15:0] legacy_touch_id_range;
    logic [15:0] new_touch_id_range;
    logic [15:0] key_id_range;
    logic [7:0]  selftest_id;
    logic [1:0]  coord_shift_mode;
    logic [1:0]  key_layout;
    logic [23:0] expected_checksum;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] key_word_first;
    logic [15:0] key_word_second;
  } decode_state_t;

  typedef struct packed {
    logic [7:0] msg_id;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic [7:0] byte_six;
    logic [7:0] byte_seven;
  } message_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  touch_id;
    logic [7:0]  touch_status;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic [15:0] key_word_first;
    logic [15:0] key_word_second;
    logic [7:0]  device_status;
    logic [23:0] device_checksum;
    logic [1:0]  update_phase;
    logic [55:0] selftest_info;
  } report_t;

  function automatic logic id_in_range(input logic [7:0] id, input logic [15:0] range);
    return (id >= range[7:0]) && (id <= range[15:8]);
  endfunction

endpackage

[rtl/trmd_decode.sv]
`timescale 1ns / 1ps

module trmd_decode import trmd_pkg::*; #(
  parameter int N_KEY_INSTANCES = KEY_INSTANCES,
  parameter bit CHECK_RESET     = CHECK_AT_RESET
) (
  input  message_t      msg,
  input  cfg_t          cfg,
  input  decode_state_t state,
  output decode_state_t state_next,
  output report_t       result
);

  logic [23:0] checksum;
  logic        checksum_ok;
  logic [1:0]  phase_upd;
  logic [11:0] legacy_x;
  logic [11:0] legacy_y;
  logic [7:0]  key_instance;

  assign checksum    = {msg.byte_four, msg.byte_three, msg.byte_two};
  assign checksum_ok = (checksum == cfg.expected_checksum);
  assign legacy_x    = {msg.byte_two, msg.byte_four[7:4]};
  assign legacy_y    = {msg.byte_three, msg.byte_four[3:0]};
  assign key_instance = msg.msg_id - cfg.key_id_range[7:0];

  always_comb begin
    phase_upd = state.phase;
    if (state.phase == PHASE_PENDING) begin
      phase_upd = checksum_ok ? PHASE_SUCCEEDED : PHASE_FAILED;
    end
    // device came out of reset with a stale configuration
    if (CHECK_RESET && msg.byte_one[STATUS_RESET_BIT] && !checksum_ok) begin
      phase_upd = PHASE_PENDING;
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    if (msg.msg_id == NO_MESSAGE_ID) begin
      result = '0;
    end else if (msg.msg_id == cfg.command_id) begin
      state_next.phase       = phase_upd;
      result.kind            = KIND_COMMAND;
      result.device_status   = msg.byte_one;
      result.device_checksum = checksum;
      result.update_phase    = phase_upd;
    end else if (id_in_range(msg.msg_id, cfg.legacy_touch_id_range)) begin
      result.kind         = KIND_TOUCH;
      result.touch_id     = msg.msg_id - cfg.legacy_touch_id_range[7:0];
      result.touch_status = msg.byte_one;
      result.x_position   = cfg.coord_shift_mode[0] ? {6'd0, legacy_x[11:2]}
                                                    : {4'd0, legacy_x};
      result.y_position   = cfg.coord_shift_mode[1] ? {6'd0, legacy_y[11:2]}
                                                    : {4'd0, legacy_y};
    end else if (id_in_range(msg.msg_id, cfg.new_touch_id_range)) begin
      result.kind         = KIND_TOUCH;
      result.touch_id     = msg.msg_id - cfg.new_touch_id_range[7:0] - 8'd2;
      result.touch_status = msg.byte_one;
      result.x_position   = {msg.byte_three, msg.byte_two};
      result.y_position   = {msg.byte_five, msg.byte_four};
    end else if (msg.msg_id == cfg.selftest_id) begin
      result.kind          = KIND_SELFTEST;
      result.selftest_info = {msg.byte_seven, msg.byte_six, msg.byte_five, msg.byte_four,
                              msg.byte_three, msg.byte_two, msg.byte_one};
    end else if (id_in_range(msg.msg_id, cfg.key_id_range)) begin
      if (cfg.key_layout == LAYOUT_PAIRED) begin
        state_next.key_word_first  = {msg.byte_three, msg.byte_two};
        state_next.key_word_second = {msg.byte_five, msg.byte_four};
      end else if (cfg.key_layout == LAYOUT_PER_INSTANCE) begin
        // instances above one hold words that are never reported
        if (key_instance == 8'd0) begin
          state_next.key_word_first = {msg.byte_three, msg.byte_two};
        end else if (key_instance == 8'd1 && N_KEY_INSTANCES > 1) begin
          state_next.key_word_second = {msg.byte_four, msg.byte_three};
        end
      end
      result.kind            = KIND_KEYS;
      result.key_word_first  = state_next.key_word_first;
      result.key_word_second = state_next.key_word_second;
    end
  end

endmodule

[rtl/touch_report_message_decoder.sv]
`timescale 1ns / 1ps

// Touch report message decoder.
// Input channel: in_valid / in_stall / in_data carry one report message (id plus
// seven bytes) per transaction. Output channel: out_valid / out_stall / out_data
// carry exactly one decoded report per message, in order; id 255 yields an
// all-zero report of kind ignored.
// Pipeline: a message is captured in the input register, decoded, and written into
// the result register, from which the receiver takes it; a stall holds it there.
// Throughput is one message per cycle while the receiver does not stall, set by the
// single decode stage between the input and result registers.
// Phase and key-word state update when a message moves into the result register.
// When the receiver stalls, the result holds; the input register still takes one
// more message, then in_stall rises until the result is taken.
// Reset (rst, synchronous) empties both stages, clears the update phase to normal,
// zeroes the key words and all configuration registers. The user must write configuration
// through the APB port only while the block is idle (unchecked); pready is always high.
module touch_report_message_decoder import trmd_pkg::*; #(
  parameter int N_KEY_INSTANCES = KEY_INSTANCES,
  parameter bit CHECK_RESET     = CHECK_AT_RESET
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  message_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output report_t               out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t          cfg;
  decode_state_t state;
  decode_state_t state_next;
  report_t       result;
  message_t      msg;
  logic          msg_valid;
  logic          advance;
  logic          load;
  logic          cfg_write;
  reg_index_t    reg_index;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_COMMAND_ID:   cfg.command_id            <= pwdata[7:0];
        REG_LEGACY_RANGE: cfg.legacy_touch_id_range <= pwdata[15:0];
        REG_NEW_RANGE:    cfg.new_touch_id_range    <= pwdata[15:0];
        REG_KEY_RANGE:    cfg.key_id_range          <= pwdata[15:0];
        REG_SELFTEST_ID:  cfg.selftest_id           <= pwdata[7:0];
        REG_SHIFT_MODE:   cfg.coord_shift_mode      <= pwdata[1:0];
        REG_KEY_LAYOUT:   cfg.key_layout            <= pwdata[1:0];
        REG_EXP_CHECKSUM: cfg.expected_checksum     <= pwdata[23:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_COMMAND_ID:   prdata = {24'd0, cfg.command_id};
      REG_LEGACY_RANGE: prdata = {16'd0, cfg.legacy_touch_id_range};
      REG_NEW_RANGE:    prdata = {16'd0, cfg.new_touch_id_range};
      REG_KEY_RANGE:    prdata = {16'd0, cfg.key_id_range};
      REG_SELFTEST_ID:  prdata = {24'd0, cfg.selftest_id};
      REG_SHIFT_MODE:   prdata = {30'd0, cfg.coord_shift_mode};
      REG_KEY_LAYOUT:   prdata = {30'd0, cfg.key_layout};
      REG_EXP_CHECKSUM: prdata = {8'd0, cfg.expected_checksum};
      default:          prdata = '0;
    endcase
  end

  // advance the input register whenever the result register is free or being taken
  assign advance  = msg_valid && !(out_valid && out_stall);
  assign in_stall = msg_valid && out_valid && out_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (load) begin
      msg_valid <= 1'b1;
    end else if (advance) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg <= in_data;
    end
  end

  trmd_decode #(
    .N_KEY_INSTANCES (N_KEY_INSTANCES),
    .CHECK_RESET     (CHECK_RESET)
  ) u_decode (
    .msg        (msg),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PHASE_NORMAL, key_word_first: 16'd0, key_word_second: 16'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_phase_only_on_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_COMMAND |-> out_data.update_phase == PHASE_NORMAL)
    else $error("update phase reported outside a command status transaction");

  a_keys_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && result.kind == KIND_KEYS) |=>
      $stable(state.key_word_first) && $stable(state.key_word_second))
    else $error("key words changed without a key transaction");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && result.kind == KIND_COMMAND) |=> $stable(state.phase))
    else $error("update phase changed without a command status transaction");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> msg_valid && out_valid)
    else $error("input stalled with a free stage");

  a_reset_phase: assert property (@(posedge clk)
    $past(rst) |-> state.phase == PHASE_NORMAL && !out_valid && !msg_valid)
    else $error("reset left state behind");

endmodule
